// ----- rtl/core/ws2812_hsv_pixel_encoder_macros.svh -----
// Assertion macros shared by the WS2812 pixel encoder RTL.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef WS2812_HSV_PIXEL_ENCODER_MACROS_SVH
`define WS2812_HSV_PIXEL_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HPE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/hpe_pkg.sv -----
// Types and constants of the WS2812 HSV pixel encoder.
// No dependencies; imported by every module of the block.
package hpe_pkg;

	typedef logic [7:0] chan_t;
	// Channel 2 is green, 1 is red, 0 is blue, so the packed word is already in G, R, B order.
	typedef logic [2:0][7:0] pix_t;

	typedef enum logic [2:0] {
		REGION_0,
		REGION_1,
		REGION_2,
		REGION_3,
		REGION_4,
		REGION_5
	} region_t;

	localparam chan_t CODE_ONE     = 8'hFC;
	localparam chan_t CODE_ZERO    = 8'hC0;
	localparam chan_t BRIGHT_RESET = 8'd77;
	localparam chan_t HUE_SPAN     = 8'd43;
	localparam chan_t CHAN_FULL    = 8'd255;
	localparam logic [3:0] FADE_MAX = 4'd15;

	// x / 15 == (x * 8739) >> 17 holds for every x below 10082.
	localparam logic [13:0] RECIP15     = 14'd8739;
	localparam int          RECIP_SHIFT = 17;

	localparam int BYTES_PER_PIXEL = 24;
	localparam int CNT_W           = $clog2(BYTES_PER_PIXEL);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- rtl/core/hpe_front.sv -----
// Front end: accepts pixel items, resolves the hue region and scales each channel.
// Four-stage pipeline with per-stage valids; depends on hpe_pkg.
module hpe_front
	import hpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  chan_t      brightness,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] hue,
	input  logic       lit,
	input  logic [3:0] tail_step,
	output logic       pix_valid,
	input  logic       pix_ready,
	output pix_t       pix
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	pix_t             raw_s1;
	logic [3:0]       fade_s1, fade_s2;
	pix_t             bri_s2;
	logic [2:0][11:0] prod_s3;
	pix_t             out_s4;

	region_t region;
	chan_t   base, diff, ramp, up, down;
	pix_t    raw;
	logic [2:0][15:0] bri_prod;
	logic [2:0][25:0] div_prod;

	assign rdy4     = !v_s4 || pix_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Region is hue / 43, found by comparison against the region boundaries.
	always_comb begin
		priority if (hue < 8'd43) begin
			region = REGION_0;
		end else if (hue < 8'd86) begin
			region = REGION_1;
		end else if (hue < 8'd129) begin
			region = REGION_2;
		end else if (hue < 8'd172) begin
			region = REGION_3;
		end else if (hue < 8'd215) begin
			region = REGION_4;
		end else begin
			region = REGION_5;
		end
	end

	always_comb begin
		base = 8'(region) * HUE_SPAN;
		diff = hue - base;
		ramp = 8'({diff, 2'b00} + {1'b0, diff, 1'b0});
		up   = ramp;
		down = CHAN_FULL - ramp;
		unique case (region)
			REGION_0: raw = {up,        CHAN_FULL, 8'd0};
			REGION_1: raw = {CHAN_FULL, down,      8'd0};
			REGION_2: raw = {CHAN_FULL, 8'd0,      up};
			REGION_3: raw = {down,      8'd0,      CHAN_FULL};
			REGION_4: raw = {8'd0,      up,        CHAN_FULL};
			REGION_5: raw = {8'd0,      CHAN_FULL, down};
			default:  raw = '0;
		endcase
		if (!lit) begin
			raw = '0;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			bri_prod[c] = 16'(raw_s1[c]) * 16'(brightness);
			div_prod[c] = 26'(prod_s3[c]) * 26'(RECIP15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			raw_s1  <= raw;
			fade_s1 <= FADE_MAX - tail_step;
		end
		if (rdy2 && v_s1) begin
			for (int c = 0; c < 3; c++) begin
				bri_s2[c] <= bri_prod[c][15:8];
			end
			fade_s2 <= fade_s1;
		end
		if (rdy3 && v_s2) begin
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= 12'(bri_s2[c]) * 12'(fade_s2);
			end
		end
		if (rdy4 && v_s3) begin
			for (int c = 0; c < 3; c++) begin
				out_s4[c] <= div_prod[c][RECIP_SHIFT +: 8];
			end
		end
	end

	assign pix_valid = v_s4;
	assign pix       = out_s4;

endmodule

// ----- rtl/core/hpe_fifo.sv -----
// Short queue of scaled pixels between the front end and the serialiser.
// Register-based, depth from hpe_pkg; uses the shared assertion macros.
`include "ws2812_hsv_pixel_encoder_macros.svh"

module hpe_fifo
	import hpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  pix_t push_data,
	output logic pop_valid,
	input  logic pop,
	output pix_t pop_data
);

	pix_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  push;

	assign push_ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`HPE_ASSERT_IMP(a_fifo_bound, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue over-filled")
	`HPE_ASSERT_IMP(a_fifo_pop_nonempty, pop, count_q != '0, "pop from an empty queue")
	`HPE_ASSERT_NXT(a_fifo_grow, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

// ----- rtl/core/hpe_serial.sv -----
// Back end: turns each queued pixel into 24 SPI code bytes, MSB first.
// Output register decouples it from the consumer; depends on hpe_pkg and the macros.
`include "ws2812_hsv_pixel_encoder_macros.svh"

module hpe_serial
	import hpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fifo_valid,
	input  pix_t  fifo_data,
	output logic  fifo_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output chan_t spi_byte,
	output logic  last
);

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BYTES_PER_PIXEL - 1);

	logic [23:0]      word_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             out_valid_q;
	chan_t            spi_byte_q;
	logic             last_q;
	logic             load_out, adv, at_last;

	assign load_out = !out_valid_q || out_ready;
	assign adv      = load_out && busy_q;
	assign at_last  = (cnt_q == LAST_IDX);
	// The next pixel is taken in the same cycle as the last byte of the current one is loaded into the output register.
	assign fifo_pop = fifo_valid && (!busy_q || (adv && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= busy_q;
			if (fifo_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				if (at_last) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			spi_byte_q <= word_q[23] ? CODE_ONE : CODE_ZERO;
			last_q     <= at_last;
		end
		if (fifo_pop) begin
			word_q <= fifo_data;
		end else if (adv) begin
			word_q <= {word_q[22:0], 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign spi_byte  = spi_byte_q;
	assign last      = last_q;

	`HPE_ASSERT_IMP(a_ser_idle_cnt, !busy_q, cnt_q == '0, "byte counter not at zero while idle")
	`HPE_ASSERT_IMP(a_ser_cnt_range, busy_q, cnt_q <= LAST_IDX, "byte counter past the last byte")
	`HPE_ASSERT_NXT(a_ser_last_flag, adv && at_last, out_valid_q && last_q,
		"final byte of a pixel not flagged")

endmodule

// ----- rtl/core/ws2812_hsv_pixel_encoder.sv -----
// Top level of the WS2812 HSV pixel encoder: brightness register, front end,
// pixel queue and byte serialiser. Depends on hpe_pkg, hpe_front, hpe_fifo, hpe_serial.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    hue[7:0], lit, tail_step[3:0]
//   output   out_valid / out_ready  spi_byte[7:0], last
//   config   cfg_we                 cfg_wdata[7:0] (brightness)
//
// Each pixel gives 24 bytes, one per cycle from the serialiser while out_ready stays high, and a queued
// next pixel follows without a gap; the serialiser's byte counter counts off the 24 bytes of each pixel.
// An accepted item passes three further front stages, the queue write, the serialiser load and the
// output register before its first byte appears.
// Reset clears all valids and sets brightness to 77; there is no clearing pass.
// The front end keeps taking items into its four stages and the four-entry queue
// while the output stalls.
module ws2812_hsv_pixel_encoder
	import hpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] hue,
	input  logic       lit,
	input  logic [3:0] tail_step,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] spi_byte,
	output logic       last
);

	chan_t brightness_q;
	logic  pix_valid, pix_ready;
	pix_t  pix;
	logic  q_valid, q_pop;
	pix_t  q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RESET;
		end else if (cfg_we) begin
			brightness_q <= cfg_wdata;
		end
	end

	hpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.brightness (brightness_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.lit        (lit),
		.tail_step  (tail_step),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix)
	);

	hpe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (pix_valid),
		.push_ready (pix_ready),
		.push_data  (pix),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	hpe_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (q_valid),
		.fifo_data  (q_data),
		.fifo_pop   (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.spi_byte   (spi_byte),
		.last       (last)
	);

endmodule

// ----- tb/sv/tb_ws2812_hsv_pixel_encoder.sv -----
// Self-checking testbench for the WS2812 HSV pixel encoder: random and directed pixels
// against an in-bench colour predictor, with random stalls on both handshakes.
// Depends on hpe_pkg and the ws2812_hsv_pixel_encoder RTL.
`timescale 1ns / 1ps

module tb_ws2812_hsv_pixel_encoder;
	import hpe_pkg::*;

	typedef struct {
		logic [7:0] hue;
		logic       lit;
		logic [3:0] step;
	} pixel_item_t;

	typedef struct {
		chan_t       code;
		logic        last;
		int unsigned pixel;
	} code_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] hue = 8'd0;
	logic       lit = 1'b0;
	logic [3:0] tail_step = 4'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] spi_byte;
	logic       last;

	pixel_item_t pixel_q[$];
	code_byte_t  code_q[$];
	chan_t       bright_now = BRIGHT_RESET;
	int unsigned pixels_taken = 0;
	int unsigned bytes_checked = 0;
	int unsigned settings_used = 1;
	int unsigned errors = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	logic        quiet;

	ws2812_hsv_pixel_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.hue       (hue),
		.lit       (lit),
		.tail_step (tail_step),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.spi_byte  (spi_byte),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// No random idling on either side while this window of pixels goes through.
	assign quiet = (pixels_taken >= 60) && (pixels_taken < 100);

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		errors++;
	endtask

	// Green, red and blue of one pixel after hue sector, brightness and tail fade.
	function automatic logic [23:0] grb_of_pixel(input pixel_item_t px, input chan_t br);
		logic [7:0]  sector_n;
		region_t     sector;
		chan_t       rise, fall, r, g, b;
		logic [3:0]  fade;
		logic [15:0] dimmed;
		chan_t       ch[3];
		sector_n = px.hue / HUE_SPAN;
		sector = region_t'(sector_n[2:0]);
		rise = 8'((px.hue - sector_n * HUE_SPAN) * 6);
		fall = CHAN_FULL - rise;
		case (sector)
			REGION_0: begin r = CHAN_FULL; g = rise;      b = 8'd0;      end
			REGION_1: begin r = fall;      g = CHAN_FULL; b = 8'd0;      end
			REGION_2: begin r = 8'd0;      g = CHAN_FULL; b = rise;      end
			REGION_3: begin r = 8'd0;      g = fall;      b = CHAN_FULL; end
			REGION_4: begin r = rise;      g = 8'd0;      b = CHAN_FULL; end
			default: begin r = CHAN_FULL; g = 8'd0;      b = fall;      end
		endcase
		fade = FADE_MAX - px.step;
		ch[0] = g;
		ch[1] = r;
		ch[2] = b;
		for (int i = 0; i < 3; i++) begin
			dimmed = (16'(ch[i]) * 16'(br)) >> 8;
			ch[i] = px.lit ? 8'((dimmed * fade) / FADE_MAX) : 8'd0;
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	task automatic expect_pixel_codes(input pixel_item_t px, input int unsigned idx);
		logic [23:0] grb;
		code_byte_t  cb;
		grb = grb_of_pixel(px, bright_now);
		for (int k = 0; k < BYTES_PER_PIXEL; k++) begin
			cb.code = grb[BYTES_PER_PIXEL - 1 - k] ? CODE_ONE : CODE_ZERO;
			cb.last = (k == BYTES_PER_PIXEL - 1);
			cb.pixel = idx;
			code_q.push_back(cb);
		end
	endtask

	// Sender: holds each item until taken, idles now and then between items.
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				nxt.hue = hue;
				nxt.lit = lit;
				nxt.step = tail_step;
				expect_pixel_codes(nxt, pixels_taken);
				pixels_taken <= pixels_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (pixel_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
					nxt = pixel_q.pop_front();
					hue <= nxt.hue;
					lit <= nxt.lit;
					tail_step <= nxt.step;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus two long hold-offs so the pipeline backs up.
	always @(posedge clk or negedge arst_n) begin : byte_sink
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && pixels_taken >= 30) ||
				(holds_done == 1 && pixels_taken >= 130)) begin
			out_ready <= 1'b0;
			hold_left <= 200;
			holds_done <= holds_done + 1;
		end else begin
			out_ready <= quiet || ($urandom_range(0, 99) >= 7);
		end
	end

	always @(posedge clk) begin : byte_monitor
		code_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (code_q.size() == 0) begin
				report_mismatch($sformatf("byte 0x%02h with no pixel outstanding", spi_byte));
			end else begin
				want = code_q.pop_front();
				if (spi_byte !== want.code)
					report_mismatch($sformatf("pixel %0d: spi_byte 0x%02h, wanted 0x%02h",
						want.pixel, spi_byte, want.code));
				if (last !== want.last)
					report_mismatch($sformatf("pixel %0d: last %b, wanted %b",
						want.pixel, last, want.last));
			end
			bytes_checked <= bytes_checked + 1;
		end
	end

	task automatic wait_drained;
		do @(negedge clk);
		while (pixel_q.size() != 0 || in_valid || code_q.size() != 0);
	endtask

	task automatic write_brightness(input chan_t value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bright_now = value;
		settings_used++;
	endtask

	task automatic queue_pixel(input logic [7:0] h, input logic on, input logic [3:0] step);
		pixel_item_t px;
		px.hue = h;
		px.lit = on;
		px.step = step;
		pixel_q.push_back(px);
	endtask

	// Mostly lit pixels; every eighth or so lands on a sector boundary.
	task automatic queue_random_pixels(input int unsigned count);
		logic [7:0] edges[8] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd172, 8'd214, 8'd255};
		logic [7:0] h;
		for (int unsigned i = 0; i < count; i++) begin
			h = ($urandom_range(0, 7) == 0) ? edges[$urandom_range(0, 7)]
				: 8'($urandom_range(0, 255));
			queue_pixel(h, $urandom_range(0, 99) < 85, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset brightness: every sector edge, unlit pixels, several tail steps and
		// the largest tail step, 15, which must come out black.
		queue_pixel(8'd0, 1'b1, 4'd0);
		queue_pixel(8'd42, 1'b1, 4'd0);
		queue_pixel(8'd43, 1'b1, 4'd0);
		queue_pixel(8'd85, 1'b1, 4'd0);
		queue_pixel(8'd86, 1'b1, 4'd0);
		queue_pixel(8'd128, 1'b1, 4'd0);
		queue_pixel(8'd129, 1'b1, 4'd0);
		queue_pixel(8'd171, 1'b1, 4'd0);
		queue_pixel(8'd172, 1'b1, 4'd0);
		queue_pixel(8'd214, 1'b1, 4'd0);
		queue_pixel(8'd215, 1'b1, 4'd0);
		queue_pixel(8'd255, 1'b1, 4'd0);
		queue_pixel(8'd255, 1'b1, 4'd14);
		queue_pixel(8'd0, 1'b1, 4'd15);
		queue_pixel(8'd100, 1'b0, 4'd0);
		queue_pixel(8'd170, 1'b0, 4'd14);
		queue_pixel(8'd21, 1'b1, 4'd7);
		queue_pixel(8'd200, 1'b1, 4'd8);
		queue_pixel(8'd60, 1'b1, 4'd1);
		queue_pixel(8'd255, 1'b0, 4'd15);

		write_brightness(8'd0);
		queue_pixel(8'd0, 1'b1, 4'd0);
		queue_pixel(8'd128, 1'b1, 4'd0);
		queue_random_pixels(30);

		write_brightness(8'd255);
		queue_random_pixels(40);

		write_brightness(8'd1);
		queue_random_pixels(30);

		write_brightness(8'($urandom_range(2, 254)));
		queue_random_pixels(30);

		write_brightness(8'($urandom_range(0, 255)));
		queue_random_pixels(30);

		wait_drained();
		repeat (24) @(posedge clk);
		if (code_q.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", code_q.size()));
		$display("Run covered %0d pixels, %0d code bytes checked, %0d brightness settings.",
			pixels_taken, bytes_checked, settings_used);
		$display("Two long output hold-offs applied; %0d mismatches seen.", errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d bytes outstanding.", code_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hpe_pkg.sv
rtl/core/hpe_front.sv
rtl/core/hpe_fifo.sv
rtl/core/hpe_serial.sv
rtl/core/ws2812_hsv_pixel_encoder.sv
tb/sv/tb_ws2812_hsv_pixel_encoder.sv
